[sv/priority_voice_ownership_arbiter_top_macros.svh]
// Assertion macros for the voice ownership arbiter.
`ifndef PRIORITY_VOICE_OWNERSHIP_ARBITER_TOP_MACROS_SVH
`define PRIORITY_VOICE_OWNERSHIP_ARBITER_TOP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PVOA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voice arbiter implication check failed");

// Check that a condition holds in every cycle out of reset.
`define PVOA_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("voice arbiter invariant check failed");

`endif

[sv/pvoa_pkg.sv]
// Shared types and codes for the voice ownership arbiter.
package pvoa_pkg;

  typedef enum logic [1:0] {
    ACT_ACQUIRE   = 2'd0,
    ACT_REL_OWNER = 2'd1,
    ACT_REL_VOICE = 2'd2,
    ACT_CLEAR     = 2'd3
  } action_t;

  localparam int CLAIM_W = 5;
  localparam int PRIOS_W = 10;
  localparam int VIDX_W  = 3;

  typedef struct packed {
    action_t              action;
    logic [7:0]           owner_id;
    logic [CLAIM_W-1:0]   claim_mask;
    logic [PRIOS_W-1:0]   claim_priorities;
    logic [VIDX_W-1:0]    voice_index;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       displaced_valid;
    logic [7:0] displaced_owner;
    logic       last;
    logic       voice_owned;
    logic [7:0] voice_owner;
    logic [1:0] voice_priority;
    logic [4:0] owned_mask;
    logic [1:0] max_priority;
  } out_item_t;

endpackage

[sv/priority_voice_ownership_arbiter_top.sv]
// Voice ownership arbiter: per-voice owner table walked one voice per cycle by a sequencer.
// A new item is taken only in idle: release voice and clear then walk the table once to report;
// release owner first frees that owner's voices; acquire checks priorities, scans for owners to
// displace, frees each one, assigns the claimed voices and reports (refused: straight to report).
// Results load one per free output cycle; a stalled result holds back only the next load.
// Reset (rst_n low, synchronous) frees every voice and empties the output register.
`include "priority_voice_ownership_arbiter_top_macros.svh"

module priority_voice_ownership_arbiter_top
  import pvoa_pkg::*;
#(
  parameter int VOICE_COUNT   = 5,
  parameter int PRIORITY_BITS = 2,
  parameter int OWNER_BITS    = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int VIW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int NDW = $clog2(VOICE_COUNT + 1);
  localparam int EW  = (VOICE_COUNT > CLAIM_W) ? VOICE_COUNT : CLAIM_W;
  localparam int PW  = (VOICE_COUNT * PRIORITY_BITS > PRIOS_W) ?
                       VOICE_COUNT * PRIORITY_BITS : PRIOS_W;
  localparam int IW  = (VIW > VIDX_W) ? VIW : VIDX_W;
  localparam logic [VIW-1:0] LAST_V = VIW'(VOICE_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FREE,
    ST_ASSIGN,
    ST_REPORT,
    ST_EMIT
  } state_t;

  state_t                   state_r;
  logic [VOICE_COUNT-1:0]   valid_r;
  logic [OWNER_BITS-1:0]    owner_r [VOICE_COUNT];
  logic [PRIORITY_BITS-1:0] prio_r  [VOICE_COUNT];
  logic [OWNER_BITS-1:0]    disp_r  [VOICE_COUNT];
  logic [NDW-1:0]           ndisp_r;
  logic [NDW-1:0]           ecnt_r;
  logic [VIW-1:0]           vcnt_r;
  logic [VIW-1:0]           scan_r;
  in_item_t                 req_r;
  logic [OWNER_BITS-1:0]    free_owner_r;
  logic                     accepted_r;
  logic [VOICE_COUNT-1:0]   owned_r;
  logic [PRIORITY_BITS-1:0] maxp_r;
  logic                     vo_r;
  logic [OWNER_BITS-1:0]    vown_r;
  logic [PRIORITY_BITS-1:0] vpr_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic [OWNER_BITS-1:0]    in_owner;
  logic [EW-1:0]            in_claim_w;
  logic                     pre_ok;
  logic                     in_vidx_ok;
  logic [VIW-1:0]           in_vidx;
  logic                     rel_hit;
  logic [OWNER_BITS-1:0]    req_owner;
  logic [EW-1:0]            req_claim_w;
  logic [PW-1:0]            req_prio_w;
  logic [PRIORITY_BITS-1:0] req_p;
  logic                     scan_hit;
  logic                     emit_last;
  logic [VIW-1:0]           eidx;
  logic                     emit_fire;

  always_comb begin
    in_owner    = OWNER_BITS'(in_data.owner_id);
    in_claim_w  = EW'(in_data.claim_mask);
    pre_ok      = (in_owner != '0) && (in_claim_w != '0) &&
                  ((in_claim_w >> VOICE_COUNT) == '0);
    in_vidx_ok  = IW'(in_data.voice_index) < IW'(VOICE_COUNT);
    in_vidx     = VIW'(in_data.voice_index);
    rel_hit     = in_vidx_ok && valid_r[in_vidx] && (owner_r[in_vidx] == in_owner);
    req_owner   = OWNER_BITS'(req_r.owner_id);
    req_claim_w = EW'(req_r.claim_mask);
    req_prio_w  = PW'(req_r.claim_priorities);
    req_p       = req_prio_w[vcnt_r * PRIORITY_BITS +: PRIORITY_BITS];
    scan_hit    = valid_r[scan_r] &&
                  ((owner_r[scan_r] == req_owner) || req_claim_w[scan_r]);
    emit_last   = (ndisp_r == '0) || (ecnt_r == ndisp_r - 1'b1);
    eidx        = ecnt_r[VIW-1:0];
    emit_fire   = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      ndisp_r     <= '0;
      ecnt_r      <= '0;
      vcnt_r      <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            req_r      <= in_data;
            ndisp_r    <= '0;
            ecnt_r     <= '0;
            vcnt_r     <= '0;
            scan_r     <= '0;
            accepted_r <= 1'b0;
            owned_r    <= '0;
            maxp_r     <= '0;
            vo_r       <= 1'b0;
            vown_r     <= '0;
            vpr_r      <= '0;
            case (in_data.action)
              ACT_ACQUIRE: begin
                state_r <= pre_ok ? ST_CHECK : ST_REPORT;
              end
              ACT_REL_OWNER: begin
                free_owner_r <= in_owner;
                state_r      <= ST_FREE;
              end
              ACT_REL_VOICE: begin
                if (rel_hit) begin
                  valid_r[in_vidx] <= 1'b0;
                end
                state_r <= ST_REPORT;
              end
              ACT_CLEAR: begin
                valid_r <= '0;
                state_r <= ST_REPORT;
              end
              default: begin
                state_r <= ST_REPORT;
              end
            endcase
          end
        end
        ST_CHECK: begin
          if (req_claim_w[vcnt_r] && valid_r[vcnt_r] && (req_p < prio_r[vcnt_r])) begin
            vcnt_r  <= '0;
            state_r <= ST_REPORT;
          end else if (vcnt_r == LAST_V) begin
            vcnt_r  <= '0;
            state_r <= ST_SCAN;
          end else begin
            vcnt_r <= vcnt_r + 1'b1;
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            disp_r[ndisp_r[VIW-1:0]] <= owner_r[scan_r];
            ndisp_r      <= ndisp_r + 1'b1;
            free_owner_r <= owner_r[scan_r];
            vcnt_r       <= '0;
            state_r      <= ST_FREE;
          end else if (scan_r == LAST_V) begin
            vcnt_r  <= '0;
            state_r <= ST_ASSIGN;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        ST_FREE: begin
          if (valid_r[vcnt_r] && (owner_r[vcnt_r] == free_owner_r)) begin
            valid_r[vcnt_r] <= 1'b0;
          end
          if (vcnt_r == LAST_V) begin
            vcnt_r <= '0;
            if (req_r.action == ACT_ACQUIRE) begin
              if (scan_r == LAST_V) begin
                state_r <= ST_ASSIGN;
              end else begin
                scan_r  <= scan_r + 1'b1;
                state_r <= ST_SCAN;
              end
            end else begin
              state_r <= ST_REPORT;
            end
          end else begin
            vcnt_r <= vcnt_r + 1'b1;
          end
        end
        ST_ASSIGN: begin
          if (req_claim_w[vcnt_r]) begin
            valid_r[vcnt_r] <= 1'b1;
            owner_r[vcnt_r] <= req_owner;
            prio_r[vcnt_r]  <= req_p;
          end
          if (vcnt_r == LAST_V) begin
            accepted_r <= 1'b1;
            vcnt_r     <= '0;
            state_r    <= ST_REPORT;
          end else begin
            vcnt_r <= vcnt_r + 1'b1;
          end
        end
        ST_REPORT: begin
          if (valid_r[vcnt_r]) begin
            owned_r[vcnt_r] <= 1'b1;
            if (prio_r[vcnt_r] > maxp_r) begin
              maxp_r <= prio_r[vcnt_r];
            end
          end
          if (IW'(vcnt_r) == IW'(req_r.voice_index)) begin
            vo_r   <= valid_r[vcnt_r];
            vown_r <= valid_r[vcnt_r] ? owner_r[vcnt_r] : '0;
            vpr_r  <= valid_r[vcnt_r] ? prio_r[vcnt_r] : '0;
          end
          if (vcnt_r == LAST_V) begin
            vcnt_r  <= '0;
            ecnt_r  <= '0;
            state_r <= ST_EMIT;
          end else begin
            vcnt_r <= vcnt_r + 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            out_data_r.accepted            <= accepted_r;
            out_data_r.displaced_valid     <= (ndisp_r != '0);
            out_data_r.displaced_owner     <= (ndisp_r != '0) ? 8'(disp_r[eidx]) : 8'd0;
            out_data_r.last                <= emit_last;
            out_data_r.voice_owned         <= vo_r;
            out_data_r.voice_owner         <= 8'(vown_r);
            out_data_r.voice_priority      <= 2'(vpr_r);
            out_data_r.owned_mask          <= 5'(owned_r);
            out_data_r.max_priority        <= 2'(maxp_r);
            if (emit_last) begin
              state_r <= ST_IDLE;
            end else begin
              ecnt_r <= ecnt_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `PVOA_ASSERT_ALWAYS(a_ndisp_bound, ndisp_r <= NDW'(VOICE_COUNT))
  `PVOA_ASSERT_IMP(a_plain_is_last, out_valid_r && !out_data_r.displaced_valid, out_data_r.last)
  `PVOA_ASSERT_IMP(a_disp_needs_grant, out_valid_r && out_data_r.displaced_valid, out_data_r.accepted)
  `PVOA_ASSERT_IMP(a_emit_from_list, state_r == ST_EMIT && ndisp_r != '0, ecnt_r < ndisp_r)

endmodule

[bench/priority_voice_ownership_arbiter_checker.sv]
// Checker for the voice ownership arbiter: tracks the voice table and compares every result.
`timescale 1ns / 100ps

module priority_voice_ownership_arbiter_checker
  import pvoa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        outstanding,
  output int        results_checked,
  output int        grants,
  output int        ousted_reports
);

  localparam int VOICES = 5;

  logic       voice_held   [VOICES];
  logic [7:0] voice_holder [VOICES];
  logic [1:0] voice_level  [VOICES];

  out_item_t expected_reports [$];

  initial begin
    fail_count      = 0;
    outstanding     = 0;
    results_checked = 0;
    grants          = 0;
    ousted_reports  = 0;
    for (int v = 0; v < VOICES; v++) begin
      voice_held[v]   = 1'b0;
      voice_holder[v] = '0;
      voice_level[v]  = '0;
    end
  end

  task automatic free_entry(input int v);
    voice_held[v]   = 1'b0;
    voice_holder[v] = '0;
    voice_level[v]  = '0;
  endtask

  task automatic apply_request(input in_item_t req);
    logic [7:0] ousted [VOICES];
    int         n_ousted;
    int         n_reports;
    logic       granted;
    logic       seen;
    logic [1:0] want;
    logic [4:0] held_mask;
    logic [1:0] top_level;
    out_item_t  rpt;
    n_ousted  = 0;
    granted   = 1'b0;
    held_mask = '0;
    top_level = '0;
    case (req.action)
      ACT_ACQUIRE: begin
        granted = (req.owner_id != 8'd0) && (req.claim_mask != '0);
        for (int v = 0; v < VOICES; v++) begin
          want = req.claim_priorities[2*v +: 2];
          if (req.claim_mask[v] && voice_held[v] && want < voice_level[v])
            granted = 1'b0;
        end
        if (granted) begin
          for (int v = 0; v < VOICES; v++) begin
            if (voice_held[v] && (voice_holder[v] == req.owner_id || req.claim_mask[v])) begin
              seen = 1'b0;
              for (int k = 0; k < n_ousted; k++)
                if (ousted[k] == voice_holder[v])
                  seen = 1'b1;
              if (!seen) begin
                ousted[n_ousted] = voice_holder[v];
                n_ousted++;
              end
            end
          end
          for (int v = 0; v < VOICES; v++)
            for (int k = 0; k < n_ousted; k++)
              if (voice_held[v] && voice_holder[v] == ousted[k])
                free_entry(v);
          for (int v = 0; v < VOICES; v++) begin
            if (req.claim_mask[v]) begin
              voice_held[v]   = 1'b1;
              voice_holder[v] = req.owner_id;
              voice_level[v]  = req.claim_priorities[2*v +: 2];
            end
          end
        end
      end
      ACT_REL_OWNER: begin
        for (int v = 0; v < VOICES; v++)
          if (voice_held[v] && voice_holder[v] == req.owner_id)
            free_entry(v);
      end
      ACT_REL_VOICE: begin
        if (req.voice_index < VOICES && voice_held[req.voice_index] &&
            voice_holder[req.voice_index] == req.owner_id)
          free_entry(int'(req.voice_index));
      end
      default: begin
        for (int v = 0; v < VOICES; v++)
          free_entry(v);
      end
    endcase

    for (int v = 0; v < VOICES; v++) begin
      if (voice_held[v]) begin
        held_mask[v] = 1'b1;
        if (voice_level[v] > top_level)
          top_level = voice_level[v];
      end
    end
    rpt                 = '0;
    rpt.accepted        = granted;
    rpt.owned_mask      = held_mask;
    rpt.max_priority    = top_level;
    if (req.voice_index < VOICES && voice_held[req.voice_index]) begin
      rpt.voice_owned    = 1'b1;
      rpt.voice_owner    = voice_holder[req.voice_index];
      rpt.voice_priority = voice_level[req.voice_index];
    end
    if (granted)
      grants++;
    n_reports = (n_ousted > 0) ? n_ousted : 1;
    for (int k = 0; k < n_reports; k++) begin
      rpt.displaced_valid = (k < n_ousted);
      rpt.displaced_owner = (k < n_ousted) ? ousted[k] : 8'd0;
      rpt.last            = (k == n_reports - 1);
      expected_reports    = {expected_reports, rpt};
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_report(input out_item_t got);
    out_item_t want;
    if (expected_reports.size() == 0) begin
      $error("result transfer with nothing outstanding: %h", got);
      fail_count++;
    end else begin
      want = expected_reports.pop_front();
      results_checked++;
      if (want.displaced_valid)
        ousted_reports++;
      check_field("accepted",        8'(want.accepted),        8'(got.accepted));
      check_field("displaced_valid", 8'(want.displaced_valid), 8'(got.displaced_valid));
      check_field("displaced_owner", want.displaced_owner,     got.displaced_owner);
      check_field("last",            8'(want.last),            8'(got.last));
      check_field("voice_owned",     8'(want.voice_owned),     8'(got.voice_owned));
      check_field("voice_owner",     want.voice_owner,         got.voice_owner);
      check_field("voice_priority",  8'(want.voice_priority),  8'(got.voice_priority));
      check_field("owned_mask",      8'(want.owned_mask),      8'(got.owned_mask));
      check_field("max_priority",    8'(want.max_priority),    8'(got.max_priority));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        apply_request(in_data);
      if (out_valid && !out_stall)
        compare_report(out_data);
    end
    outstanding = expected_reports.size();
  end

endmodule

[bench/tb_priority_voice_ownership_arbiter_top.sv]
// Testbench top for the voice ownership arbiter: stimulus, stall pattern, watchdog and verdict.
`timescale 1ns / 100ps

module tb_priority_voice_ownership_arbiter_top
  import pvoa_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 40;
  localparam int TAIL_CYCLES = 80;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  int fail_count;
  int outstanding;
  int results_checked;
  int grants;
  int ousted_reports;

  int idle_pct  = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int directed_sent = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  priority_voice_ownership_arbiter_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  priority_voice_ownership_arbiter_checker scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .grants         (grants),
    .ousted_reports (ousted_reports)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_item_t voice_request(input action_t act, input logic [7:0] owner,
                                             input logic [4:0] mask, input logic [9:0] prios,
                                             input logic [2:0] vidx);
    in_item_t r;
    r.action           = act;
    r.owner_id         = owner;
    r.claim_mask       = mask;
    r.claim_priorities = prios;
    r.voice_index      = vidx;
    return r;
  endfunction

  function automatic in_item_t random_request();
    in_item_t r;
    int       pick;
    pick = $urandom_range(19);
    if (pick == 0)
      r.owner_id = 8'd0;
    else if (pick < 4)
      r.owner_id = 8'($urandom_range(255));
    else
      r.owner_id = 8'($urandom_range(1, 4));
    r.claim_priorities = 10'($urandom_range(1023));
    r.voice_index = ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    if ($urandom_range(19) == 0)
      r.claim_mask = '0;
    else if ($urandom_range(1) == 0)
      r.claim_mask = 5'(1 << $urandom_range(4));
    else
      r.claim_mask = 5'($urandom_range(1, 31));
    pick = $urandom_range(99);
    if (pick < 55)
      r.action = ACT_ACQUIRE;
    else if (pick < 72)
      r.action = ACT_REL_OWNER;
    else if (pick < 94)
      r.action = ACT_REL_VOICE;
    else
      r.action = ACT_CLEAR;
    return r;
  endfunction

  task automatic send_request(input in_item_t req);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    items_sent++;
  endtask

  initial begin
    in_item_t directed [$];
    int       phase_idle  [4];
    int       phase_stall [4];
    phase_idle  = '{0, 76, 0, 29};
    phase_stall = '{0, 0, 76, 29};

    directed = {directed, voice_request(ACT_ACQUIRE,   8'h00, 5'b00001, 10'h3FF, 3'd0)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'h01, 5'b00000, 10'h3FF, 3'd0)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'h01, 5'b00011, 10'h000, 3'd1)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'h02, 5'b01100, 10'h0A0, 3'd2)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'hFF, 5'b10000, 10'h300, 3'd4)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'h03, 5'b11111, 10'h155, 3'd3)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'h03, 5'b11111, 10'h3FF, 3'd0)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'h03, 5'b00001, 10'h3FF, 3'd0)};
    directed = {directed, voice_request(ACT_REL_OWNER, 8'h00, 5'b11111, 10'h3FF, 3'd0)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'h01, 5'b00010, 10'h000, 3'd1)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'h02, 5'b00100, 10'h010, 3'd2)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'h04, 5'b01000, 10'h080, 3'd3)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'h05, 5'b10000, 10'h000, 3'd4)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'h06, 5'b11111, 10'h3FF, 3'd4)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'h07, 5'b00001, 10'h3FF, 3'd0)};
    directed = {directed, voice_request(ACT_REL_VOICE, 8'h09, 5'b00000, 10'h000, 3'd0)};
    directed = {directed, voice_request(ACT_REL_VOICE, 8'h07, 5'b00000, 10'h000, 3'd0)};
    directed = {directed, voice_request(ACT_REL_VOICE, 8'h07, 5'b00000, 10'h000, 3'd5)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'h80, 5'b10101, 10'h2AA, 3'd7)};
    directed = {directed, voice_request(ACT_REL_OWNER, 8'h80, 5'b00000, 10'h000, 3'd2)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'h55, 5'b11111, 10'h3FF, 3'd6)};
    directed = {directed, voice_request(ACT_CLEAR,     8'h00, 5'b00000, 10'h000, 3'd4)};
    directed = {directed, voice_request(ACT_ACQUIRE,   8'hFF, 5'b11111, 10'h000, 3'd3)};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_request(directed[i]);
    directed_sent = items_sent;

    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
        send_request(random_request());
    end
    in_valid  <= 1'b0;
    stall_pct = 0;

    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d directed) under four idle and stall mixes.",
             items_sent, directed_sent);
    $display("Checked %0d results: %0d grants, %0d displaced owners reported.",
             results_checked, grants, ousted_reports);
    if (fail_count == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
